// ===== rtl/sso_pkg.sv =====
// ----------------------------------------------------------------------------
// sso_pkg: shared types, constants and the quarter-wave sine table
// Holds the sequencer states, register indexes, divider request/response
// records and the elaboration-time table builder.
// ----------------------------------------------------------------------------
package sso_pkg;

    localparam int MAX_HEIGHT      = 2048;
    localparam int SCATTER_STEP    = 1;
    localparam int SINE_TABLE_SIZE = 1024;
    localparam int SIN_IDX_W       = $clog2(SINE_TABLE_SIZE + 1);
    localparam int PCT_DEN         = 100;
    // reciprocal of the percent divisor, exact for products below 2^23
    localparam int PCT_SHIFT       = 30;
    localparam int PCT_RECIP       = (2**PCT_SHIFT + PCT_DEN - 1) / PCT_DEN;
    localparam int NUM_W           = 32;
    localparam int DEN_W           = 17;

    typedef logic [14:0] t_sine_rom [0:SINE_TABLE_SIZE];

    typedef enum logic [4:0] {
        S_IDLE,
        S_TICK_FC,
        S_TICK_PH,
        S_ROW_C,
        S_ROW_CHK,
        S_ROW_A2,
        S_ROM_M,
        S_MUL_D,
        S_ROW_RP,
        S_ROW_SA,
        S_ROM_T,
        S_MUL_T,
        S_ROW_WA,
        S_ROM_W,
        S_MUL_LO,
        S_MUL_HI,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        CFG_CYCLE_LENGTH  = 4'd0,
        CFG_COUNT_LIMIT   = 4'd1,
        CFG_RIGHT_SWAY    = 4'd2,
        CFG_LEFT_SWAY     = 4'd3,
        CFG_RETURN_PCT    = 4'd4,
        CFG_INVERT_ROWS   = 4'd5,
        CFG_SCATTER_AMP   = 4'd6,
        CFG_SCATTER_PER   = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

    // Taylor series of sin over the first quarter turn, Q30 in, Q15 out.
    function automatic t_sine_rom f_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] q;
        for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
            x    = 64'd1686629713 * 64'(i) / SINE_TABLE_SIZE;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            q = ($unsigned(sum) + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            rom[i] = q[14:0];
        end
        return rom;
    endfunction

    // Table address for a Q16 turn angle, folded into the first quadrant.
    function automatic logic [SIN_IDX_W-1:0] f_sin_addr(input logic [15:0] ang);
        logic [14+SIN_IDX_W-1:0] prod;
        logic [SIN_IDX_W-1:0]    idx;
        prod = (14+SIN_IDX_W)'(ang[13:0]) * (14+SIN_IDX_W)'(SINE_TABLE_SIZE)
             + (14+SIN_IDX_W)'(8192);
        idx  = prod[14+SIN_IDX_W-1:14];
        if (ang[14]) begin
            idx = SIN_IDX_W'(SINE_TABLE_SIZE) - idx;
        end
        if (idx > SIN_IDX_W'(SINE_TABLE_SIZE)) begin
            idx = SIN_IDX_W'(SINE_TABLE_SIZE);
        end
        return idx;
    endfunction

endpackage

// ===== rtl/sso_div.sv =====
// ----------------------------------------------------------------------------
// sso_div: restoring divider, one quotient bit per cycle
// Takes a request, runs NUM_W steps and pulses done with quotient and
// remainder held until the next start.
// ----------------------------------------------------------------------------
module sso_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sso_pkg::t_div_req i_req,
    output sso_pkg::t_div_rsp o_rsp
);
    import sso_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [$clog2(NUM_W)-1:0] r_cnt;
    logic [DEN_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_q;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W:0]           trial;
    logic                     fits;

    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(NUM_W)'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/scanline_sway_offset_generator.sv =====
// ----------------------------------------------------------------------------
// scanline_sway_offset_generator: per-row horizontal sway displacement
// Sequencer around a shared divider, one small multiplier and a sine ROM.
// ----------------------------------------------------------------------------
// A tick transfer advances the frame counter and the scatter phase and gives
// no result; a row transfer gives one signed offset, or none when the row lies
// outside the picture. Work runs one item at a time and o_ready is high only
// while the sequencer idles. Almost every cycle goes to the shared 32-step
// restoring divider: a tick costs two divisions (one with no wrap), a row costs
// three divisions without ripple or five with it (one fewer with no wrap), plus
// a handful of ROM and multiply steps. The return split is taken by a
// reciprocal multiply. A finished offset sits in the output register, so the
// next item may be taken before it is drained. No clearing pass follows reset.
module scanline_sway_offset_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [10:0] i_row_index,
    input  logic [11:0] i_picture_height,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [12:0] o_row_offset,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sso_pkg::*;

    localparam t_sine_rom SINE_ROM = f_sine_rom();

    // configuration
    logic [15:0]        r_cycle_length;
    logic [15:0]        r_count_limit;
    logic signed [10:0] r_right_sway;
    logic signed [10:0] r_left_sway;
    logic [6:0]         r_return_pct;
    logic               r_invert_rows;
    logic [9:0]         r_scatter_amp;
    logic [11:0]        r_scatter_per;

    // sequencer and datapath
    t_state             r_state;
    t_state             n_state;
    logic [15:0]        r_fc;
    logic [10:0]        r_ph;
    logic               r_issued;
    logic [10:0]        r_row;
    logic [11:0]        r_h;
    logic [15:0]        r_c;
    logic [16:0]        r_d;
    logic [22:0]        r_pct_cl;
    logic               r_ret;
    logic [10:0]        r_x;
    logic [15:0]        r_ang;
    logic [14:0]        r_tab;
    logic               r_neg;
    logic signed [29:0] r_delta;
    logic signed [29:0] r_t;
    logic signed [29:0] r_s;
    logic [30:0]        r_plo;
    logic signed [31:0] r_phi;
    logic               r_ovalid;
    logic signed [12:0] r_offset;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic [11:0]        h_in;
    logic               row_reject;
    logic [11:0]        per;
    logic [15:0]        fc_inc;
    logic [15:0]        c_raw;
    logic [15:0]        c_clamped;
    logic [46:0]        chk_prod;
    logic [16:0]        chk;
    logic               chk_ret;
    logic signed [17:0] chk_dd;
    logic [11:0]        k_row;
    logic               rom_en;
    logic signed [15:0] sinval;
    logic signed [17:0] cm;
    logic signed [11:0] rl_sum;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;
    logic signed [47:0] prod;
    logic signed [47:0] v_rnd;
    logic signed [47:0] v_adj;
    logic signed [16:0] res;
    logic signed [12:0] res_sat;

    sso_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Configuration writes; out-of-range indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_length <= 16'd20;
            r_count_limit  <= 16'd20;
            r_right_sway   <= 11'sd10;
            r_left_sway    <= 11'sd10;
            r_return_pct   <= 7'd50;
            r_invert_rows  <= 1'b0;
            r_scatter_amp  <= 10'd0;
            r_scatter_per  <= 12'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CYCLE_LENGTH: r_cycle_length <= i_cfg_data;
                CFG_COUNT_LIMIT:  r_count_limit  <= i_cfg_data;
                CFG_RIGHT_SWAY:   r_right_sway   <= $signed(i_cfg_data[10:0]);
                CFG_LEFT_SWAY:    r_left_sway    <= $signed(i_cfg_data[10:0]);
                CFG_RETURN_PCT:   r_return_pct   <= i_cfg_data[6:0];
                CFG_INVERT_ROWS:  r_invert_rows  <= i_cfg_data[0];
                CFG_SCATTER_AMP:  r_scatter_amp  <= i_cfg_data[9:0];
                CFG_SCATTER_PER:  r_scatter_per  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Helper terms
    // ------------------------------------------------------------------
    always_comb begin
        // tall pictures are taken at the maximum height
        h_in = (i_picture_height > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : i_picture_height;
        row_reject = (h_in == 12'd0) || ({1'b0, i_row_index} >= h_in);

        // ripple period held to 1..MAX_HEIGHT rows
        if (r_scatter_per == 12'd0) begin
            per = 12'd1;
        end else if (r_scatter_per > 12'd2048) begin
            per = 12'd2048;
        end else begin
            per = r_scatter_per;
        end

        fc_inc = r_fc + 16'd1;

        // frame position, clamped below the count limit
        c_raw = (r_cycle_length == 16'd0) ? r_fc : div_rsp.rem[15:0];
        if (r_count_limit == 16'd0) begin
            c_clamped = 16'd0;
        end else if (c_raw >= r_count_limit) begin
            c_clamped = r_count_limit - 16'd1;
        end else begin
            c_clamped = c_raw;
        end

        // outward or return part of the cycle; percent split by reciprocal
        chk_prod = 47'(r_pct_cl) * 47'(PCT_RECIP);
        chk      = chk_prod[PCT_SHIFT+16:PCT_SHIFT];
        chk_ret  = {1'b0, r_c} >= chk;
        chk_dd   = chk_ret ? ($signed({2'b00, r_cycle_length}) - $signed({1'b0, chk}))
                           : $signed({1'b0, chk});

        k_row = r_invert_rows ? (r_h - {1'b0, r_row}) : {1'b0, r_row};

        sinval = r_neg ? -$signed({1'b0, r_tab}) : $signed({1'b0, r_tab});
        cm     = 18'sd32768 - 18'(sinval);
        rl_sum = 12'(r_right_sway) + 12'(r_left_sway);

        // exact product of (delta + t) and w from two partial products
        prod  = (48'(r_phi) <<< 15) + $signed({17'd0, r_plo});
        v_rnd = prod + 48'sd1073741824;
        v_adj = v_rnd + (v_rnd[47] ? 48'sd2147483647 : 48'sd0);
        res   = v_adj[47:31];
        if (res > 17'sd4095) begin
            res_sat = 13'sd4095;
        end else if (res < -17'sd4096) begin
            res_sat = -13'sd4096;
        end else begin
            res_sat = res[12:0];
        end
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Sequencer: next state, divider requests, multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        div_req = '0;
        rom_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_action) begin
                        n_state = S_TICK_FC;
                    end else if (!row_reject) begin
                        n_state = S_ROW_C;
                    end
                end
            end
            S_TICK_FC: begin
                if (r_cycle_length == 16'd0) begin
                    n_state = S_TICK_PH;
                end else begin
                    div_req.start = !r_issued;
                    div_req.num   = NUM_W'(fc_inc);
                    div_req.den   = DEN_W'(r_cycle_length);
                    if (div_rsp.done) begin
                        n_state = S_TICK_PH;
                    end
                end
            end
            S_TICK_PH: begin
                div_req.start = !r_issued;
                div_req.num   = NUM_W'({1'b0, r_ph} + 12'(SCATTER_STEP));
                div_req.den   = DEN_W'(per);
                if (div_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            S_ROW_C: begin
                if (r_cycle_length == 16'd0) begin
                    n_state = S_ROW_CHK;
                end else begin
                    div_req.start = !r_issued;
                    div_req.num   = NUM_W'(r_fc);
                    div_req.den   = DEN_W'(r_cycle_length);
                    if (div_rsp.done) begin
                        n_state = S_ROW_CHK;
                    end
                end
            end
            S_ROW_CHK: begin
                n_state = S_ROW_A2;
            end
            S_ROW_A2: begin
                div_req.start = !r_issued;
                div_req.num   = {1'b0, r_c, 15'd0} + NUM_W'(r_d[16:1]);
                div_req.den   = r_d;
                if (div_rsp.done) begin
                    n_state = S_ROM_M;
                end
            end
            S_ROM_M: begin
                rom_en  = 1'b1;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                mul_a   = 18'(rl_sum);
                mul_b   = cm;
                n_state = (r_scatter_amp != 10'd0) ? S_ROW_RP : S_ROW_WA;
            end
            S_ROW_RP: begin
                div_req.start = !r_issued;
                div_req.num   = NUM_W'({1'b0, r_row} + {1'b0, r_ph});
                div_req.den   = DEN_W'(per);
                if (div_rsp.done) begin
                    n_state = S_ROW_SA;
                end
            end
            S_ROW_SA: begin
                div_req.start = !r_issued;
                div_req.num   = NUM_W'({r_x, 16'd0}) + NUM_W'(per[11:1]);
                div_req.den   = DEN_W'(per);
                if (div_rsp.done) begin
                    n_state = S_ROM_T;
                end
            end
            S_ROM_T: begin
                rom_en  = 1'b1;
                n_state = S_MUL_T;
            end
            S_MUL_T: begin
                mul_a   = $signed({8'd0, r_scatter_amp});
                mul_b   = 18'(sinval);
                n_state = S_ROW_WA;
            end
            S_ROW_WA: begin
                div_req.start = !r_issued;
                div_req.num   = NUM_W'({k_row, 14'd0}) + NUM_W'(r_h[11:1]);
                div_req.den   = DEN_W'(r_h);
                if (div_rsp.done) begin
                    n_state = S_ROM_W;
                end
            end
            S_ROM_W: begin
                rom_en  = 1'b1;
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                mul_a   = $signed({3'd0, r_s[14:0]});
                mul_b   = cm;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                mul_a   = 18'($signed(r_s[29:15]));
                mul_b   = cm;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_fc     <= '0;
            r_ph     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_req.start) begin
                r_issued <= 1'b1;
            end else if (div_rsp.done) begin
                r_issued <= 1'b0;
            end
            if (r_state == S_TICK_FC) begin
                if (r_cycle_length == 16'd0) begin
                    r_fc <= fc_inc;
                end else if (div_rsp.done) begin
                    r_fc <= div_rsp.rem[15:0];
                end
            end
            if (r_state == S_TICK_PH && div_rsp.done) begin
                r_ph <= div_rsp.rem[10:0];
            end
            if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rom_en) begin
            r_tab <= SINE_ROM[f_sin_addr(r_ang)];
            r_neg <= r_ang[15];
        end
        case (r_state)
            S_IDLE: begin
                r_row <= i_row_index;
                r_h   <= h_in;
            end
            S_ROW_C: begin
                r_pct_cl <= 23'(r_return_pct) * 23'(r_cycle_length);
                if (r_cycle_length == 16'd0 || div_rsp.done) begin
                    r_c <= c_clamped;
                end
            end
            S_ROW_CHK: begin
                r_ret <= chk_ret;
                if (chk_ret) begin
                    r_c <= r_c - chk[15:0];
                end
                r_d <= (chk_dd < 18'sd1) ? 17'd1 : chk_dd[16:0];
            end
            S_ROW_A2: begin
                if (div_rsp.done) begin
                    r_ang <= div_rsp.quo[15:0] + 16'd16384;
                end
            end
            S_MUL_D: begin
                r_t <= '0;
                if (r_ret) begin
                    r_delta <= $signed({{3{r_right_sway[10]}}, r_right_sway, 16'd0})
                             - mul_p[29:0];
                end else begin
                    r_delta <= mul_p[29:0]
                             - $signed({{3{r_left_sway[10]}}, r_left_sway, 16'd0});
                end
            end
            S_ROW_RP: begin
                if (div_rsp.done) begin
                    r_x <= div_rsp.rem[10:0];
                end
            end
            S_ROW_SA: begin
                if (div_rsp.done) begin
                    r_ang <= div_rsp.quo[15:0] + 16'd16384;
                end
            end
            S_MUL_T: begin
                r_t <= {mul_p[28:0], 1'b0};
            end
            S_ROW_WA: begin
                if (div_rsp.done) begin
                    r_ang <= div_rsp.quo[15:0];
                end
            end
            S_ROM_W: begin
                r_s <= r_delta + r_t;
            end
            S_MUL_LO: begin
                r_plo <= mul_p[30:0];
            end
            S_MUL_HI: begin
                r_phi <= mul_p[31:0];
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    r_offset <= res_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_row_offset = r_offset;

`ifndef SYNTHESIS
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> !div_req.start)
        else $error("divider restarted while busy");

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_TICK_FC || r_state == S_TICK_PH ||
                          r_state == S_ROW_C || r_state == S_ROW_A2 ||
                          r_state == S_ROW_RP || r_state == S_ROW_SA ||
                          r_state == S_ROW_WA))
        else $error("divider result arrived outside a divide step");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result raised without a finished row");
`endif

endmodule

// ===== verif/scanline_sway_offset_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_sway_offset_generator_test: self-checking bench for the sway block
// Drives tick and row transfers with random gaps and back-pressure, predicts
// row offsets in fixed point or takes typed ones, and checks each output transfer in order.
// ----------------------------------------------------------------------------
module scanline_sway_offset_generator_test;

    import sso_pkg::*;

    localparam logic [3:0] CFG_SPARE    = 4'd12;  // beyond the register list
    localparam int         ITEMS_PHASE  = 250;
    localparam int         RAND_PHASES  = 8;
    localparam int         SETTLE       = 300;    // cycles for a tick in flight
    localparam logic       ACT_TICK     = 1'b0;
    localparam logic       ACT_ROW      = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [10:0] i_row_index;
    logic [11:0] i_picture_height;
    logic        o_valid;
    logic        i_ready;
    logic signed [12:0] o_row_offset;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    scanline_sway_offset_generator dut (.*);

    // Directed stimulus row: an offset is typed in only where obvious.
    typedef struct {
        logic        act;
        logic [10:0] row;
        logic [11:0] height;
        bit          typed;     // expectation typed in, not predicted
        bit          has_off;   // typed expectation carries an offset
        logic signed [12:0] off;
    } t_stim;

    // Predictor state
    longint      sine_rom [0:SINE_TABLE_SIZE];
    logic [15:0] sway_cfg [0:7];
    longint      frame_cnt;
    longint      ripple_phase;

    logic signed [12:0] offset_queue [$];
    t_stim       stim_table [$];
    int          mismatches = 0;
    int          items_sent;
    bit          hold_off;
    bit          calm;

    // ------------------------------------------------------------------
    // Clock and the overall time limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #30_000_000;
        $display("scanline_sway_offset_generator_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic build_sine_rom();
        longint unsigned x, x2, term;
        longint sum, q;
        for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
            x    = 64'd1686629713 * i / SINE_TABLE_SIZE;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) sum = 0;
            q = (sum + 16384) >>> 15;
            if (q > 32767) q = 32767;
            sine_rom[i] = q;
        end
    endtask

    function automatic longint sine_q15(longint ang);
        longint a, quad, idx, v;
        a    = ang & 16'hFFFF;
        quad = a >> 14;
        idx  = ((a & 16'h3FFF) * SINE_TABLE_SIZE + 8192) >> 14;
        if (quad % 2 == 1) idx = SINE_TABLE_SIZE - idx;
        if (idx > SINE_TABLE_SIZE) idx = SINE_TABLE_SIZE;
        v = sine_rom[idx];
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint ripple_period();
        longint p;
        p = sway_cfg[CFG_SCATTER_PER];
        if (p < 1) p = 1;
        if (p > 2048) p = 2048;
        return p;
    endfunction

    task automatic store_cfg(input logic [3:0] idx, input logic [15:0] data);
        case (idx)
            CFG_CYCLE_LENGTH: sway_cfg[CFG_CYCLE_LENGTH] = data;
            CFG_COUNT_LIMIT:  sway_cfg[CFG_COUNT_LIMIT]  = data;
            CFG_RIGHT_SWAY:   sway_cfg[CFG_RIGHT_SWAY]   = data & 16'h07FF;
            CFG_LEFT_SWAY:    sway_cfg[CFG_LEFT_SWAY]    = data & 16'h07FF;
            CFG_RETURN_PCT:   sway_cfg[CFG_RETURN_PCT]   = data & 16'h007F;
            CFG_INVERT_ROWS:  sway_cfg[CFG_INVERT_ROWS]  = data & 16'h0001;
            CFG_SCATTER_AMP:  sway_cfg[CFG_SCATTER_AMP]  = data & 16'h03FF;
            CFG_SCATTER_PER:  sway_cfg[CFG_SCATTER_PER]  = data & 16'h0FFF;
            default: ;
        endcase
    endtask

    // Advance state for one transfer; returns 1 with the offset for a row inside the picture.
    function automatic bit predict_offset(input logic act, input logic [10:0] row_in,
                                          input logic [11:0] h_in,
                                          output logic signed [12:0] off);
        longint cl, lim, c, chk, d, a2, m, r, l, delta, t, p, sa, k, h, row, wa, w;
        longint prod, v, res;
        bit     back;
        off = '0;
        cl  = sway_cfg[CFG_CYCLE_LENGTH];
        if (act == ACT_TICK) begin
            frame_cnt = (frame_cnt + 1) & 16'hFFFF;
            if (cl != 0) frame_cnt = frame_cnt % cl;
            ripple_phase = (ripple_phase + SCATTER_STEP) % ripple_period();
            return 1'b0;
        end
        row = row_in;
        h   = h_in;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (h == 0 || row >= h) return 1'b0;

        lim = sway_cfg[CFG_COUNT_LIMIT];
        c   = frame_cnt;
        if (cl != 0) c = c % cl;
        if (lim == 0) c = 0;
        else if (c >= lim) c = lim - 1;

        chk  = sway_cfg[CFG_RETURN_PCT] * cl / 100;
        back = c >= chk;
        if (back) begin
            c = c - chk;
            d = cl - chk;
        end else begin
            d = chk;
        end
        if (d < 1) d = 1;
        a2 = ((c * 32768 + d / 2) / d) & 16'hFFFF;
        m  = 32768 - sine_q15(a2 + 16384);

        r = longint'($signed(sway_cfg[CFG_RIGHT_SWAY][10:0]));
        l = longint'($signed(sway_cfg[CFG_LEFT_SWAY][10:0]));
        if (!back) delta = -l * 65536 + (r + l) * m;
        else       delta = r * 65536 - (r + l) * m;

        t = 0;
        if (sway_cfg[CFG_SCATTER_AMP] != 0) begin
            p  = ripple_period();
            sa = (((row + ripple_phase) % p) * 65536 + p / 2) / p;
            t  = longint'(sway_cfg[CFG_SCATTER_AMP]) * sine_q15(sa + 16384) * 2;
        end

        k  = sway_cfg[CFG_INVERT_ROWS][0] ? h - row : row;
        wa = (k * 16384 + h / 2) / h;
        w  = 32768 - sine_q15(wa);

        prod = (delta + t) * w;
        v    = prod + (longint'(1) <<< 30);
        if (v >= 0) res = v >>> 31;
        else        res = -((-v) >>> 31);
        if (res > 4095)  res = 4095;
        if (res < -4096) res = -4096;
        off = res[12:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always begin : sink
        int stall;
        while (i_rst_n !== 1'b1) begin
            i_ready <= 1'b0;
            @(posedge i_clk);
        end
        while (hold_off) begin
            i_ready <= 1'b0;
            @(posedge i_clk);
        end
        stall = calm ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
            i_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        i_ready <= 1'b1;
        @(posedge i_clk);
        while (!o_valid && !hold_off) @(posedge i_clk);
    end

    // Starve the output for a long stretch once the random part is under way,
    // so the result register fills and input transfers back up.
    initial begin : pressure
        hold_off = 1'b0;
        wait (items_sent >= 700);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Compare every output transfer against the oldest expectation.
    always @(posedge i_clk) begin
        logic signed [12:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (offset_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected offset %0d with nothing expected", o_row_offset);
            end else begin
                want = offset_queue.pop_front();
                if (o_row_offset !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row_offset mismatch: expected %0d got %0d",
                                 want, o_row_offset);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one transfer after a random gap; hold valid while gaps are zero.
    task automatic send_item(input t_stim s);
        int gap;
        logic signed [12:0] off;
        bit got;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_action         <= s.act;
        i_row_index      <= s.row;
        i_picture_height <= s.height;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        got = predict_offset(s.act, s.row, s.height, off);
        if (s.typed) begin
            if (s.has_off) offset_queue.push_back(s.off);
        end else if (got) begin
            offset_queue.push_back(off);
        end
    endtask

    // Drop valid and wait for every result, then for any tick in flight.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (offset_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        store_cfg(idx, data);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] v [0:7]);
        write_reg(CFG_CYCLE_LENGTH, v[0]);
        write_reg(CFG_COUNT_LIMIT,  v[1]);
        write_reg(CFG_RIGHT_SWAY,   v[2]);
        write_reg(CFG_LEFT_SWAY,    v[3]);
        write_reg(CFG_RETURN_PCT,   v[4]);
        write_reg(CFG_INVERT_ROWS,  v[5]);
        write_reg(CFG_SCATTER_AMP,  v[6]);
        write_reg(CFG_SCATTER_PER,  v[7]);
        @(posedge i_clk);
    endtask

    function automatic t_stim pick(input logic act, input logic [10:0] row,
                                   input logic [11:0] h);
        t_stim s;
        s.act = act; s.row = row; s.height = h;
        s.typed = 1'b0; s.has_off = 1'b0; s.off = '0;
        return s;
    endfunction

    function automatic t_stim random_item();
        int   roll;
        logic [11:0] h;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return pick(ACT_TICK, 11'($urandom), 12'($urandom));
        end else if (roll < 88) begin
            // well-formed row inside the picture
            h = (roll < 70) ? 12'($urandom_range(1, 4095)) : 12'($urandom_range(1, 64));
            return pick(ACT_ROW, 11'($urandom_range(0, (h > 2048 ? 2048 : h) - 1)), h);
        end
        // noise: rows that may fall outside the picture
        return pick(ACT_ROW, 11'($urandom), 12'($urandom_range(0, 4095)));
    endfunction

    initial begin : stimulus
        logic [15:0] regs [0:7];
        t_stim       s;

        i_rst_n = 1'b0; i_valid = 1'b0; i_action = ACT_TICK;
        i_row_index = '0; i_picture_height = '0;
        i_cfg_we = 1'b0; i_cfg_index = CFG_CYCLE_LENGTH; i_cfg_data = '0;
        items_sent = 0; calm = 1'b0;

        build_sine_rom();
        sway_cfg[CFG_CYCLE_LENGTH] = 16'd20;
        sway_cfg[CFG_COUNT_LIMIT]  = 16'd20;
        sway_cfg[CFG_RIGHT_SWAY]   = 16'd10;
        sway_cfg[CFG_LEFT_SWAY]    = 16'd10;
        sway_cfg[CFG_RETURN_PCT]   = 16'd50;
        sway_cfg[CFG_INVERT_ROWS]  = 16'd0;
        sway_cfg[CFG_SCATTER_AMP]  = 16'd0;
        sway_cfg[CFG_SCATTER_PER]  = 16'd1;
        frame_cnt = 0; ripple_phase = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset settings: top row at rest, rows outside
        // the picture, a zero height, a tall picture, then a walk over the cycle.
        s = pick(ACT_ROW, 11'd0, 12'd1);
        s.typed = 1'b1; s.has_off = 1'b1; s.off = -13'sd9;
        stim_table.push_back(s);
        s = pick(ACT_ROW, 11'd3, 12'd3);    s.typed = 1'b1; stim_table.push_back(s);
        s = pick(ACT_ROW, 11'd0, 12'd0);    s.typed = 1'b1; stim_table.push_back(s);
        s = pick(ACT_ROW, 11'd2047, 12'd2047); s.typed = 1'b1; stim_table.push_back(s);
        stim_table.push_back(pick(ACT_ROW, 11'd2047, 12'd4095));
        stim_table.push_back(pick(ACT_ROW, 11'd0, 12'd2048));
        stim_table.push_back(pick(ACT_ROW, 11'd1023, 12'd2048));
        for (int i = 0; i < 7; i++) begin
            stim_table.push_back(pick(ACT_TICK, 11'h7FF, 12'hFFF));
            stim_table.push_back(pick(ACT_ROW, 11'(i * 37), 12'd300));
        end
        stim_table.push_back(pick(ACT_ROW, 11'd1, 12'd2));
        foreach (stim_table[i]) send_item(stim_table[i]);
        drain();

        // Spare register index: must leave every setting alone.
        write_reg(CFG_SPARE, 16'hFFFF);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: regs = '{16'd0, 16'd65535, 16'h0400, 16'h03FF, 16'd0,
                            16'd1, 16'd1023, 16'd2048};
                1: regs = '{16'd65535, 16'd1, 16'h03FF, 16'h0400, 16'd100,
                            16'd0, 16'd1, 16'd0};
                2: regs = '{16'd1, 16'd0, 16'h07FF, 16'h0000, 16'd100,
                            16'd1, 16'd512, 16'd4095};
                default: regs = '{16'($urandom_range(0, 48)), 16'($urandom_range(1, 60)),
                                  16'($urandom), 16'($urandom),
                                  16'($urandom_range(0, 100)), 16'($urandom_range(0, 1)),
                                  16'($urandom_range(0, 1023)), 16'($urandom_range(1, 2048))};
            endcase
            write_all(regs);
            calm = (ph == 4);
            for (int n = 0; n < ITEMS_PHASE; n++) send_item(random_item());
            drain();
        end

        while (offset_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && offset_queue.size() == 0) begin
            $display("scanline_sway_offset_generator_test: clean");
        end else begin
            $display("scanline_sway_offset_generator_test: errors");
        end
        $finish;
    end

endmodule
